// ----- rtl/core/mmc3_pkg.sv -----
package mmc3_pkg;

  // Item operation codes; codes 6 and 7 are unused.
  typedef enum logic [2:0] {
    OP_WRITE_LOW  = 3'd0,
    OP_WRITE_HIGH = 3'd1,
    OP_SCANLINE   = 3'd2,
    OP_READ_LOW   = 3'd3,
    OP_PRG_XLATE  = 3'd4,
    OP_CHR_XLATE  = 3'd5
  } op_t;

  // Target of a bank data write, from bank_select[2:0].
  typedef enum logic [2:0] {
    TGT_CHR_PAIR0   = 3'd0,
    TGT_CHR_PAIR1   = 3'd1,
    TGT_CHR_SINGLE0 = 3'd2,
    TGT_CHR_SINGLE1 = 3'd3,
    TGT_CHR_SINGLE2 = 3'd4,
    TGT_CHR_SINGLE3 = 3'd5,
    TGT_PRG_A       = 3'd6,
    TGT_PRG_B       = 3'd7
  } bank_tgt_t;

  // Mirroring codes on the result.
  typedef enum logic [1:0] {
    MIRROR_VERTICAL   = 2'd0,
    MIRROR_HORIZONTAL = 2'd1,
    MIRROR_QUAD       = 2'd2
  } mirror_t;

  // Configuration register indexes.
  localparam logic [1:0] REG_PRG_BANK_COUNT  = 2'd0;
  localparam logic [1:0] REG_CHR_ROM_PRESENT = 2'd1;
  localparam logic [1:0] REG_FOUR_SCREEN     = 2'd2;

  // High-area write decode.
  localparam logic [15:0] HI_DECODE_MASK  = 16'hE001;
  localparam logic [15:0] HI_BANK_SELECT  = 16'h8000;
  localparam logic [15:0] HI_BANK_DATA    = 16'h8001;
  localparam logic [15:0] HI_MIRROR       = 16'hA000;
  localparam logic [15:0] HI_IRQ_LATCH    = 16'hC000;
  localparam logic [15:0] HI_IRQ_RELOAD   = 16'hC001;
  localparam logic [15:0] HI_IRQ_DISABLE  = 16'hE000;
  localparam logic [15:0] HI_IRQ_ENABLE   = 16'hE001;

  localparam logic [15:0] LOW_WRITE_LIMIT = 16'h6000;
  localparam logic [15:0] PRG_AREA_BASE   = 16'h8000;
  localparam logic [8:0]  LAST_VIS_LINE   = 9'd239;
  localparam logic [7:0]  PAIR_MASK       = 8'hFE;

endpackage

// ----- rtl/core/mmc3_bank_mapper_with_scanline_irq_top.sv -----
// A request accepted into the input register moves on to the result register once the result
//   slot is free (input register, then result register); throughput is one request per cycle,
//   sustained under no back-pressure.
// The rate is set by the single decode/update pass between the two registers.
// Reset: rst_n is synchronous, active low; it clears both valid flags, loads the power-on bank
//   map (PRG 0/1, CHR 0,2,4,5,6,7), clears IRQ state and sets the configuration defaults.
module mmc3_bank_mapper_with_scanline_irq_top (
  input  logic              clk,
  input  logic              rst_n,
  // request channel
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [2:0]        in_op,
  input  logic [15:0]       in_addr,
  input  logic [7:0]        in_data,
  input  logic signed [9:0] in_scanline,
  input  logic              in_render_enabled,
  // result channel
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_read_data,
  output logic [8:0]        out_bank,
  output logic              out_irq_out,
  output logic [1:0]        out_mirror_mode,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [3:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import mmc3_pkg::*;

  // Configuration registers
  logic [8:0] prg_bank_count_r;
  logic       chr_rom_present_r;
  logic       four_screen_r;

  // Input register stage
  logic              s1_valid_r;
  logic [2:0]        op_r;
  logic [15:0]       addr_r;
  logic [7:0]        data_r;
  logic signed [9:0] scanline_r;
  logic              render_r;

  // Mapper state
  logic [7:0] bank_select_r, bank_select_nxt;
  logic [7:0] prg_bank_a_r, prg_bank_a_nxt;
  logic [7:0] prg_bank_b_r, prg_bank_b_nxt;
  logic [7:0] chr_pair_r   [2];
  logic [7:0] chr_pair_nxt [2];
  logic [7:0] chr_single_r   [4];
  logic [7:0] chr_single_nxt [4];
  logic       chr_off_lo_r, chr_off_lo_nxt;
  logic       chr_off_hi_r, chr_off_hi_nxt;
  logic [7:0] irq_latch_r, irq_latch_nxt;
  logic [7:0] irq_count_r, irq_count_nxt;
  logic       irq_reload_r, irq_reload_nxt;
  logic       irq_enable_r, irq_enable_nxt;
  logic       irq_line_r, irq_line_nxt;
  logic       mirror_h_r, mirror_h_nxt;

  // Result register
  logic       out_valid_r;
  logic [7:0] read_data_r, read_data_nxt;
  logic [8:0] bank_r, bank_nxt;
  logic       irq_out_r;
  logic [1:0] mirror_mode_r, mirror_mode_nxt;

  logic advance;
  logic cfg_write;

  // Move the held request into the result register whenever the result slot frees up.
  assign advance  = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || advance;

  assign out_valid       = out_valid_r;
  assign out_read_data   = read_data_r;
  assign out_bank        = bank_r;
  assign out_irq_out     = irq_out_r;
  assign out_mirror_mode = mirror_mode_r;

  // ---------------------------------------------------------------------------
  // Configuration port: always ready, write on the access phase.
  // ---------------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    prdata = '0;
    case (paddr[3:2])
      REG_PRG_BANK_COUNT:  prdata = {23'd0, prg_bank_count_r};
      REG_CHR_ROM_PRESENT: prdata = {31'd0, chr_rom_present_r};
      REG_FOUR_SCREEN:     prdata = {31'd0, four_screen_r};
      default:             prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_bank_count_r  <= 9'd32;
      chr_rom_present_r <= 1'b1;
      four_screen_r     <= 1'b0;
    end else if (cfg_write) begin
      case (paddr[3:2])
        REG_PRG_BANK_COUNT:  prg_bank_count_r  <= pwdata[8:0];
        REG_CHR_ROM_PRESENT: chr_rom_present_r <= pwdata[0];
        REG_FOUR_SCREEN:     four_screen_r     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Input register: capture a request whenever the stage is empty or draining.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r       <= in_op;
      addr_r     <= in_addr;
      data_r     <= in_data;
      scanline_r <= in_scanline;
      render_r   <= in_render_enabled;
    end
  end

  // ---------------------------------------------------------------------------
  // Single decode/update pass for the held request.
  // ---------------------------------------------------------------------------
  logic [15:0] hi_sel;
  logic [8:0]  prg_last;
  logic [8:0]  prg_second_last;
  logic        prg_swap;
  logic [2:0]  chr_slot;
  logic        chr_half;
  logic [8:0]  chr_base;
  logic        chr_off;
  logic        line_visible;
  logic [7:0]  count_tick;

  always_comb begin
    // Hold all state unless the request changes it.
    bank_select_nxt = bank_select_r;
    prg_bank_a_nxt  = prg_bank_a_r;
    prg_bank_b_nxt  = prg_bank_b_r;
    chr_pair_nxt    = chr_pair_r;
    chr_single_nxt  = chr_single_r;
    chr_off_lo_nxt  = chr_off_lo_r;
    chr_off_hi_nxt  = chr_off_hi_r;
    irq_latch_nxt   = irq_latch_r;
    irq_count_nxt   = irq_count_r;
    irq_reload_nxt  = irq_reload_r;
    irq_enable_nxt  = irq_enable_r;
    irq_line_nxt    = irq_line_r;
    mirror_h_nxt    = mirror_h_r;
    read_data_nxt   = '0;
    bank_nxt        = '0;

    hi_sel = addr_r & HI_DECODE_MASK;

    // PRG map: the two fixed banks sit at the top of the ROM, wrapping in 9 bits.
    prg_last        = prg_bank_count_r - 9'd1;
    prg_second_last = prg_bank_count_r - 9'd2;
    prg_swap        = bank_select_r[6];

    // CHR map: bit 7 of bank select swaps which half gets the 2 KiB pairs.
    chr_slot = addr_r[12:10];
    chr_half = chr_slot[2] ^ bank_select_r[7];
    if (!chr_half) begin
      chr_base = {1'b0, chr_pair_r[chr_slot[1]]} + {8'd0, chr_slot[0]};
    end else begin
      chr_base = {1'b0, chr_single_r[chr_slot[1:0]]};
    end
    // The offset follows the unswapped address half.
    chr_off = chr_slot[2] ? chr_off_hi_r : chr_off_lo_r;

    // Visible line: non-negative and at most the last rendered line.
    line_visible = !scanline_r[9] && (scanline_r[8:0] <= LAST_VIS_LINE);

    // Reload or decrement, then the zero check sees the new count.
    if (irq_reload_r) begin
      count_tick = irq_latch_r;
    end else if (irq_count_r != 8'd0) begin
      count_tick = irq_count_r - 8'd1;
    end else begin
      count_tick = irq_count_r;
    end

    case (op_r)
      OP_WRITE_LOW: begin
        if (addr_r < LOW_WRITE_LIMIT) begin
          chr_off_lo_nxt = data_r[0];
          chr_off_hi_nxt = data_r[4];
        end
      end
      OP_WRITE_HIGH: begin
        case (hi_sel)
          HI_BANK_SELECT: bank_select_nxt = data_r;
          HI_BANK_DATA: begin
            case (bank_select_r[2:0])
              TGT_CHR_PAIR0:   chr_pair_nxt[0]   = data_r & PAIR_MASK;
              TGT_CHR_PAIR1:   chr_pair_nxt[1]   = data_r & PAIR_MASK;
              TGT_CHR_SINGLE0: chr_single_nxt[0] = data_r;
              TGT_CHR_SINGLE1: chr_single_nxt[1] = data_r;
              TGT_CHR_SINGLE2: chr_single_nxt[2] = data_r;
              TGT_CHR_SINGLE3: chr_single_nxt[3] = data_r;
              TGT_PRG_A:       prg_bank_a_nxt    = data_r;
              default:         prg_bank_b_nxt    = data_r;
            endcase
          end
          HI_MIRROR: begin
            if (!four_screen_r) begin
              mirror_h_nxt = data_r[0];
            end
          end
          HI_IRQ_LATCH:  irq_latch_nxt  = data_r;
          HI_IRQ_RELOAD: irq_reload_nxt = 1'b1;
          HI_IRQ_DISABLE: begin
            irq_enable_nxt = 1'b0;
            irq_line_nxt   = 1'b0;
          end
          HI_IRQ_ENABLE: irq_enable_nxt = 1'b1;
          default: ;
        endcase
      end
      OP_SCANLINE: begin
        if (line_visible && render_r) begin
          irq_count_nxt  = count_tick;
          irq_reload_nxt = 1'b0;
          if (count_tick == 8'd0) begin
            irq_reload_nxt = 1'b1;
            if (irq_enable_r && (irq_latch_r != 8'd0)) begin
              irq_line_nxt = 1'b1;
            end
          end
        end
      end
      OP_READ_LOW: read_data_nxt = addr_r[15:8];
      OP_PRG_XLATE: begin
        if (addr_r >= PRG_AREA_BASE) begin
          case (addr_r[14:13])
            2'd0:    bank_nxt = prg_swap ? prg_second_last : {1'b0, prg_bank_a_r};
            2'd1:    bank_nxt = {1'b0, prg_bank_b_r};
            2'd2:    bank_nxt = prg_swap ? {1'b0, prg_bank_a_r} : prg_second_last;
            default: bank_nxt = prg_last;
          endcase
        end
      end
      OP_CHR_XLATE: begin
        bank_nxt = chr_base;
        if (chr_rom_present_r) begin
          bank_nxt = chr_base + {chr_off, 8'd0};
        end
      end
      default: ;
    endcase

    if (four_screen_r) begin
      mirror_mode_nxt = MIRROR_QUAD;
    end else if (mirror_h_nxt) begin
      mirror_mode_nxt = MIRROR_HORIZONTAL;
    end else begin
      mirror_mode_nxt = MIRROR_VERTICAL;
    end
  end

  // ---------------------------------------------------------------------------
  // State and result registers: commit only when the request advances.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bank_select_r   <= 8'd0;
      prg_bank_a_r    <= 8'd0;
      prg_bank_b_r    <= 8'd1;
      chr_pair_r[0]   <= 8'd0;
      chr_pair_r[1]   <= 8'd2;
      chr_single_r[0] <= 8'd4;
      chr_single_r[1] <= 8'd5;
      chr_single_r[2] <= 8'd6;
      chr_single_r[3] <= 8'd7;
      chr_off_lo_r    <= 1'b0;
      chr_off_hi_r    <= 1'b0;
      irq_latch_r     <= 8'd0;
      irq_count_r     <= 8'd0;
      irq_reload_r    <= 1'b0;
      irq_enable_r    <= 1'b0;
      irq_line_r      <= 1'b0;
      mirror_h_r      <= 1'b0;
    end else if (advance) begin
      bank_select_r <= bank_select_nxt;
      prg_bank_a_r  <= prg_bank_a_nxt;
      prg_bank_b_r  <= prg_bank_b_nxt;
      chr_pair_r    <= chr_pair_nxt;
      chr_single_r  <= chr_single_nxt;
      chr_off_lo_r  <= chr_off_lo_nxt;
      chr_off_hi_r  <= chr_off_hi_nxt;
      irq_latch_r   <= irq_latch_nxt;
      irq_count_r   <= irq_count_nxt;
      irq_reload_r  <= irq_reload_nxt;
      irq_enable_r  <= irq_enable_nxt;
      irq_line_r    <= irq_line_nxt;
      mirror_h_r    <= mirror_h_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      read_data_r   <= read_data_nxt;
      bank_r        <= bank_nxt;
      irq_out_r     <= irq_line_nxt;
      mirror_mode_r <= mirror_mode_nxt;
    end
  end

endmodule

// ----- dv/tb_mmc3_bank_mapper_with_scanline_irq_top.sv -----
module tb_mmc3_bank_mapper_with_scanline_irq_top;
  import mmc3_pkg::*;

  // Op codes the block must treat as no-ops; the package names only the used ones.
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 100;

  // One CPU/PPU request as it goes onto the input channel.
  typedef struct {
    logic [2:0]        op;
    logic [15:0]       addr;
    logic [7:0]        data;
    logic signed [9:0] scanline;
    logic              render;
  } mapper_req_t;

  // What the mapper should answer for one request.
  typedef struct {
    logic [7:0] read_data;
    logic [8:0] bank;
    logic       irq;
    mirror_t    mirror;
  } mapper_result_t;

  logic              clk;
  logic              rst_n = 1'b0;

  logic              in_valid = 1'b0;
  logic              in_ready;
  logic [2:0]        in_op = '0;
  logic [15:0]       in_addr = '0;
  logic [7:0]        in_data = '0;
  logic signed [9:0] in_scanline = '0;
  logic              in_render_enabled = 1'b0;

  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [7:0]        out_read_data;
  logic [8:0]        out_bank;
  logic              out_irq_out;
  logic [1:0]        out_mirror_mode;

  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [3:0]        paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  mmc3_bank_mapper_with_scanline_irq_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_op             (in_op),
    .in_addr           (in_addr),
    .in_data           (in_data),
    .in_scanline       (in_scanline),
    .in_render_enabled (in_render_enabled),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_read_data     (out_read_data),
    .out_bank          (out_bank),
    .out_irq_out       (out_irq_out),
    .out_mirror_mode   (out_mirror_mode),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  // Shadow copy of the configuration registers, at their reset values.
  logic [8:0] sh_prg_banks   = 9'd32;
  logic       sh_chr_rom     = 1'b1;
  logic       sh_four_screen = 1'b0;

  // Shadow copy of the mapper state; power-on map assumes CHR ROM, as at reset.
  logic [7:0] sh_bank_sel    = 8'd0;
  logic [7:0] sh_prg_a       = 8'd0;
  logic [7:0] sh_prg_b       = 8'd1;
  logic [7:0] sh_chr_pair   [2] = '{8'd0, 8'd2};
  logic [7:0] sh_chr_single [4] = '{8'd4, 8'd5, 8'd6, 8'd7};
  logic       sh_off_lo      = 1'b0;
  logic       sh_off_hi      = 1'b0;
  logic [7:0] sh_irq_latch   = 8'd0;
  logic [7:0] sh_irq_count   = 8'd0;
  logic       sh_irq_reload  = 1'b0;
  logic       sh_irq_enable  = 1'b0;
  logic       sh_irq         = 1'b0;
  logic       sh_mirror_h    = 1'b0;

  mapper_req_t    pending_requests[$];
  mapper_result_t pending_results[$];

  int items_queued  = 0;
  int results_seen  = 0;
  int err_cnt       = 0;
  int irq_raise_cnt = 0;
  int settings_cnt  = 1;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case a request or result never gets through.
  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  // Advance the shadow mapper by one accepted request and return its answer.
  function automatic mapper_result_t mapper_apply(mapper_req_t r);
    mapper_result_t res;
    logic [8:0]     last_bank;
    logic [8:0]     second_last;
    logic [2:0]     slot;
    logic [8:0]     v;
    int             line;
    res.read_data = 8'd0;
    res.bank      = 9'd0;
    case (r.op)
      OP_WRITE_LOW: begin
        // CHR offset selects live only below the save-RAM window
        if (r.addr < LOW_WRITE_LIMIT) begin
          sh_off_lo = r.data[0];
          sh_off_hi = r.data[4];
        end
      end
      OP_WRITE_HIGH: begin
        case (r.addr & HI_DECODE_MASK)
          HI_BANK_SELECT: sh_bank_sel = r.data;
          HI_BANK_DATA: begin
            case (bank_tgt_t'(sh_bank_sel[2:0]))
              TGT_CHR_PAIR0:   sh_chr_pair[0] = r.data & PAIR_MASK;
              TGT_CHR_PAIR1:   sh_chr_pair[1] = r.data & PAIR_MASK;
              TGT_CHR_SINGLE0: sh_chr_single[0] = r.data;
              TGT_CHR_SINGLE1: sh_chr_single[1] = r.data;
              TGT_CHR_SINGLE2: sh_chr_single[2] = r.data;
              TGT_CHR_SINGLE3: sh_chr_single[3] = r.data;
              TGT_PRG_A:       sh_prg_a = r.data;
              default:         sh_prg_b = r.data;
            endcase
          end
          HI_MIRROR: begin
            if (!sh_four_screen) sh_mirror_h = r.data[0];
          end
          HI_IRQ_LATCH:   sh_irq_latch = r.data;
          HI_IRQ_RELOAD:  sh_irq_reload = 1'b1;
          HI_IRQ_DISABLE: begin
            sh_irq_enable = 1'b0;
            sh_irq        = 1'b0;
          end
          HI_IRQ_ENABLE:  sh_irq_enable = 1'b1;
          default: ;  // save-RAM control and unmapped addresses do nothing
        endcase
      end
      OP_SCANLINE: begin
        line = r.scanline;
        if (r.render && line >= 0 && line <= int'(LAST_VIS_LINE)) begin
          if (sh_irq_reload) begin
            sh_irq_count  = sh_irq_latch;
            sh_irq_reload = 1'b0;
          end else if (sh_irq_count != 8'd0) begin
            sh_irq_count = sh_irq_count - 8'd1;
          end
          if (sh_irq_count == 8'd0) begin
            sh_irq_reload = 1'b1;
            if (sh_irq_enable && sh_irq_latch != 8'd0) begin
              if (!sh_irq) irq_raise_cnt++;
              sh_irq = 1'b1;
            end
          end
        end
      end
      OP_READ_LOW: res.read_data = r.addr[15:8];
      OP_PRG_XLATE: begin
        // fixed banks come from the bank count and wrap at 9 bits
        last_bank   = sh_prg_banks - 9'd1;
        second_last = sh_prg_banks - 9'd2;
        if (r.addr >= PRG_AREA_BASE) begin
          case (r.addr[14:13])
            2'd0:    res.bank = sh_bank_sel[6] ? second_last : {1'b0, sh_prg_a};
            2'd1:    res.bank = {1'b0, sh_prg_b};
            2'd2:    res.bank = sh_bank_sel[6] ? {1'b0, sh_prg_a} : second_last;
            default: res.bank = last_bank;
          endcase
        end
      end
      OP_CHR_XLATE: begin
        // only bits 12..10 pick the slot; bit 7 of bank select swaps the halves
        slot = r.addr[12:10];
        if (slot[2] ^ sh_bank_sel[7]) v = {1'b0, sh_chr_single[slot[1:0]]};
        else v = {1'b0, sh_chr_pair[slot[1]]} + {8'd0, slot[0]};
        if (sh_chr_rom) v = v + {(slot[2] ? sh_off_hi : sh_off_lo), 8'd0};
        res.bank = v;
      end
      default: ;  // spare op codes leave everything alone
    endcase
    res.irq    = sh_irq;
    res.mirror = sh_four_screen ? MIRROR_QUAD :
                 (sh_mirror_h ? MIRROR_HORIZONTAL : MIRROR_VERTICAL);
    return res;
  endfunction

  function automatic void push_request(logic [2:0] op, logic [15:0] addr, logic [7:0] data,
                                       logic signed [9:0] line, logic render);
    mapper_req_t r;
    r.op       = op;
    r.addr     = addr;
    r.data     = data;
    r.scanline = line;
    r.render   = render;
    pending_requests.push_back(r);
    items_queued++;
  endfunction

  // High-area address for a register code, with the undecoded bits scrambled.
  function automatic logic [15:0] hi_addr(logic [15:0] code);
    return code | (16'($urandom) & ~HI_DECODE_MASK);
  endfunction

  // Request driver: present queued requests in bursts, with random gaps between them.
  mapper_req_t cur_req;
  int          burst_left = 0;
  int          gap_left   = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      next_valid = in_valid;
      // predict at the edge that accepts the request
      if (in_valid && in_ready) begin
        pending_results.push_back(mapper_apply(cur_req));
        next_valid = 1'b0;
      end
      // hold a stalled request untouched; otherwise pick the next one or idle
      if (!next_valid) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_requests.size() != 0) begin
          cur_req = pending_requests.pop_front();
          in_op             <= cur_req.op;
          in_addr           <= cur_req.addr;
          in_data           <= cur_req.data;
          in_scanline       <= cur_req.scanline;
          in_render_enabled <= cur_req.render;
          next_valid = 1'b1;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(0, 40);
            gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
          end
        end
      end
      in_valid <= next_valid;
    end
  end

  // Result monitor: compare each accepted result with the oldest prediction,
  // and throttle out_ready with flow/stall runs of random length.
  int flow_left  = 0;
  int stall_left = 0;

  always @(posedge clk) begin
    mapper_result_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with no request outstanding: read_data %0h bank %0h",
                 out_read_data, out_bank);
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          if (out_read_data !== want.read_data) begin
            $error("read_data mismatch: expected %0h, got %0h", want.read_data, out_read_data);
            err_cnt++;
          end
          if (out_bank !== want.bank) begin
            $error("bank mismatch: expected %0h, got %0h", want.bank, out_bank);
            err_cnt++;
          end
          if (out_irq_out !== want.irq) begin
            $error("irq_out mismatch: expected %0b, got %0b", want.irq, out_irq_out);
            err_cnt++;
          end
          if (out_mirror_mode !== want.mirror) begin
            $error("mirror_mode mismatch: expected %0d, got %0d", want.mirror, out_mirror_mode);
            err_cnt++;
          end
        end
      end
      if (flow_left > 0) begin
        flow_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        flow_left  = $urandom_range(1, 40);
        stall_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
        out_ready <= 1'b1;
      end
    end
  end

  // Write one register through the APB port, then read it back.
  task automatic cfg_write_check(input logic [1:0] idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== val) begin
      $error("prdata mismatch at register %0d: expected %0h, got %0h", idx, val, prdata);
      err_cnt++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Program all three registers and mirror them into the shadow copy.
  task automatic set_config(input logic [8:0] n_banks, input logic rom, input logic fs);
    cfg_write_check(REG_PRG_BANK_COUNT, {23'd0, n_banks});
    sh_prg_banks = n_banks;
    cfg_write_check(REG_CHR_ROM_PRESENT, {31'd0, rom});
    sh_chr_rom = rom;
    cfg_write_check(REG_FOUR_SCREEN, {31'd0, fs});
    sh_four_screen = fs;
    settings_cnt++;
  endtask

  // Wait until every queued request has produced its result, then let the pipe settle.
  task automatic wait_drained();
    while (results_seen < items_queued) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed register sequences with random content, plus loose noise.
  task automatic queue_random_traffic(input int n_items);
    int         stop_at;
    int         line;
    logic [2:0] op;
    logic [15:0] addr;
    stop_at = items_queued + n_items;
    while (items_queued < stop_at) begin
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // bank select, bank data, then look through the new map
          push_request(OP_WRITE_HIGH, hi_addr(HI_BANK_SELECT), 8'($urandom), 10'd0, 1'b0);
          push_request(OP_WRITE_HIGH, hi_addr(HI_BANK_DATA), 8'($urandom), 10'd0, 1'b0);
          repeat ($urandom_range(1, 4))
            push_request($urandom_range(0, 1) ? OP_PRG_XLATE : OP_CHR_XLATE, 16'($urandom),
                         8'($urandom), 10'd0, 1'b0);
        end
        3, 4, 5: begin
          // arm the counter, then run a stretch of consecutive scanlines
          push_request(OP_WRITE_HIGH, hi_addr(HI_IRQ_LATCH),
                       ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6)),
                       10'd0, 1'b0);
          if ($urandom_range(0, 3) != 0)
            push_request(OP_WRITE_HIGH, hi_addr(HI_IRQ_RELOAD), 8'($urandom), 10'd0, 1'b0);
          push_request(OP_WRITE_HIGH,
                       hi_addr(($urandom_range(0, 3) != 0) ? HI_IRQ_ENABLE : HI_IRQ_DISABLE),
                       8'($urandom), 10'd0, 1'b0);
          line = $urandom_range(0, 250);
          repeat ($urandom_range(3, 16)) begin
            push_request(OP_SCANLINE, 16'($urandom), 8'($urandom), 10'(line),
                         $urandom_range(0, 7) != 0);
            line++;
            if (line > 261) line = -1;
          end
          if ($urandom_range(0, 1) != 0)
            push_request(OP_WRITE_HIGH, hi_addr(HI_IRQ_DISABLE), 8'($urandom), 10'd0, 1'b0);
        end
        default: begin
          // single request with any op code, biased toward meaningful addresses
          op   = 3'($urandom_range(0, 7));
          addr = 16'($urandom);
          if (op == OP_WRITE_HIGH && $urandom_range(0, 3) != 0) addr[15] = 1'b1;
          if (op == OP_WRITE_LOW && $urandom_range(0, 3) != 0)
            addr = 16'($urandom_range(0, int'(LOW_WRITE_LIMIT) - 1));
          push_request(op, addr, 8'($urandom), 10'($urandom_range(0, 262) - 1),
                       1'($urandom));
        end
      endcase
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // power-on PRG map, including an address below the PRG area
    push_request(OP_PRG_XLATE, 16'h8000, 8'h00, 10'd0, 1'b0);
    push_request(OP_PRG_XLATE, 16'hC000, 8'h00, 10'd0, 1'b0);
    push_request(OP_PRG_XLATE, 16'hFFFF, 8'h00, 10'd0, 1'b0);
    push_request(OP_PRG_XLATE, 16'h7FFF, 8'h00, 10'd0, 1'b0);
    // CHR slots; the last one has high address bits set that must be ignored
    push_request(OP_CHR_XLATE, 16'h0000, 8'h00, 10'd0, 1'b0);
    push_request(OP_CHR_XLATE, 16'h1C00, 8'h00, 10'd0, 1'b0);
    push_request(OP_CHR_XLATE, 16'hE800, 8'h00, 10'd0, 1'b0);
    // set both offsets, then a write at the save-RAM boundary that must not clear them
    push_request(OP_WRITE_LOW, 16'h0000, 8'h11, 10'd0, 1'b0);
    push_request(OP_WRITE_LOW, LOW_WRITE_LIMIT, 8'h00, 10'd0, 1'b0);
    push_request(OP_CHR_XLATE, 16'h1000, 8'h00, 10'd0, 1'b0);
    // both swap bits on, program PRG-B with the top value
    push_request(OP_WRITE_HIGH, HI_BANK_SELECT, 8'hC7, 10'd0, 1'b0);
    push_request(OP_WRITE_HIGH, HI_BANK_DATA, 8'hFF, 10'd0, 1'b0);
    push_request(OP_PRG_XLATE, 16'h8000, 8'h00, 10'd0, 1'b0);
    // mirroring, save-RAM control and an unmapped high write
    push_request(OP_WRITE_HIGH, HI_MIRROR, 8'hFF, 10'd0, 1'b0);
    push_request(OP_WRITE_HIGH, 16'hA001, 8'h00, 10'd0, 1'b0);
    push_request(OP_WRITE_HIGH, 16'h7FFF, 8'hFF, 10'd0, 1'b0);
    // latch of one fires on the second visible line; off-screen lines do nothing
    push_request(OP_WRITE_HIGH, HI_IRQ_LATCH, 8'h01, 10'd0, 1'b0);
    push_request(OP_WRITE_HIGH, HI_IRQ_RELOAD, 8'h00, 10'd0, 1'b0);
    push_request(OP_WRITE_HIGH, HI_IRQ_ENABLE, 8'h00, 10'd0, 1'b0);
    push_request(OP_SCANLINE, 16'h0000, 8'h00, 10'd0, 1'b1);
    push_request(OP_SCANLINE, 16'h0000, 8'h00, -10'sd1, 1'b1);
    push_request(OP_SCANLINE, 16'h0000, 8'h00, 10'd1, 1'b1);
    push_request(OP_SCANLINE, 16'h0000, 8'h00, 10'd240, 1'b1);
    push_request(OP_WRITE_HIGH, HI_IRQ_DISABLE, 8'h00, 10'd0, 1'b0);
    // spare op codes and an open-bus read at the top of the map
    push_request(OP_SPARE_6, 16'hFFFF, 8'hFF, 10'd261, 1'b1);
    push_request(OP_SPARE_7, 16'hFFFF, 8'hFF, 10'd261, 1'b1);
    push_request(OP_READ_LOW, 16'hFFFF, 8'h00, 10'd0, 1'b0);
    wait_drained();

    // smallest PRG count, CHR RAM, four-screen wiring
    set_config(9'd2, 1'b0, 1'b1);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_drained();
    // largest PRG count, CHR ROM, switchable mirroring
    set_config(9'd256, 1'b1, 1'b0);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_drained();
    // two random settings in between
    repeat (2) begin
      set_config(9'($urandom_range(2, 256)), 1'($urandom), 1'($urandom));
      queue_random_traffic(RANDOM_PER_PHASE);
      wait_drained();
    end
    // back to the reset values
    set_config(9'd32, 1'b1, 1'b0);
    queue_random_traffic(RANDOM_PER_PHASE);
    wait_drained();

    if (pending_results.size() != 0) begin
      $error("%0d predicted results never arrived", pending_results.size());
      err_cnt++;
    end
    $display("checked %0d results for %0d requests over %0d mapper settings",
             results_seen, items_queued, settings_cnt);
    $display("bank writes, translations and scanline runs raised the IRQ line %0d times",
             irq_raise_cnt);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
